@@ rtl/rtpls_pkg.sv @@
// ============================================================================
// rtpls_pkg
// Shared types, constants and state encodings for the RTP receiver statistics
// block.
// ============================================================================
package rtpls_pkg;

    localparam int SEQ_W      = 16;
    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int JIT_SHIFT  = 4;
    localparam int JIT_ROUND  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
    localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_number;
        logic [WORD_W-1:0] arrival_ms;
    } rtpls_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]         recent_seq;
        logic signed [WORD_W-1:0] lost_total;
        logic [FRAC_W-1:0]        loss_fraction;
        logic signed [WORD_W-1:0] jitter_value;
        logic [WORD_W-1:0]        received_count;
    } rtpls_result_t;

    // Request handed from the front part to the divider side.
    typedef struct packed {
        logic [SEQ_W-1:0]         recent_seq;
        logic signed [WORD_W-1:0] lost_total;
        logic [WORD_W-1:0]        expected_total;
        logic signed [WORD_W-1:0] jitter_value;
        logic [WORD_W-1:0]        received_count;
        logic                     frac_en;
    } rtpls_job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIFF,
        F_JIT
    } rtpls_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_WAIT
    } rtpls_back_state_t;

endpackage

@@ rtl/rtpls_front.sv @@
// ============================================================================
// rtpls_front
// Accepts packet requests, updates sequence, totals and jitter state, and
// hands one job per packet to the request queue.
// ============================================================================
module rtpls_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rtpls_pkg::SEQ_W-1:0]        cfg_data,
    input  logic                               push,
    output logic                               full,
    input  rtpls_pkg::rtpls_item_t             item,
    output logic                               q_push,
    input  logic                               q_full,
    output rtpls_pkg::rtpls_job_t              q_data
);

    rtpls_pkg::rtpls_front_state_t state_reg, state_next;

    logic [rtpls_pkg::SEQ_W-1:0]   next_exp_reg;
    logic [rtpls_pkg::WORD_W-1:0]  exp_tot_reg;
    logic [rtpls_pkg::WORD_W-1:0]  rec_tot_reg;
    logic [rtpls_pkg::WORD_W-1:0]  last_arr_reg;
    logic [rtpls_pkg::WORD_W-1:0]  jitter_reg;
    logic [rtpls_pkg::SEQ_W-1:0]   seq_reg;
    logic [rtpls_pkg::WORD_W-1:0]  delta_reg;
    logic                          jit_en_reg;
    logic signed [rtpls_pkg::WORD_W:0] t_reg;

    logic                          accept;
    logic                          jit_upd;
    logic [rtpls_pkg::SEQ_W-1:0]   diff16;
    logic [rtpls_pkg::WORD_W-1:0]  exp_add;
    logic [rtpls_pkg::WORD_W-1:0]  d32;
    logic signed [rtpls_pkg::WORD_W:0] t_next;
    logic signed [rtpls_pkg::WORD_W:0] q_shift;
    logic                          q_corr;
    logic [rtpls_pkg::WORD_W-1:0]  jitter_new;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtpls_pkg::F_IDLE: if (push) state_next = rtpls_pkg::F_DIFF;
            rtpls_pkg::F_DIFF: state_next = rtpls_pkg::F_JIT;
            rtpls_pkg::F_JIT:  if (!q_full) state_next = rtpls_pkg::F_IDLE;
            default:           state_next = rtpls_pkg::F_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        full    = (state_reg != rtpls_pkg::F_IDLE);
        accept  = push && (state_reg == rtpls_pkg::F_IDLE);
        jit_upd = (state_reg == rtpls_pkg::F_JIT) && !q_full;
        q_push  = jit_upd;
    end

    // Datapath
    always_comb
    begin
        diff16  = item.seq_number - next_exp_reg;
        exp_add = diff16[rtpls_pkg::SEQ_W-1] ? '0
                : ({{(rtpls_pkg::WORD_W-rtpls_pkg::SEQ_W){1'b0}}, diff16}
                   + rtpls_pkg::WORD_W'(1));
        d32     = delta_reg - jitter_reg;
        t_next  = $signed({d32[rtpls_pkg::WORD_W-1], d32})
                + (rtpls_pkg::WORD_W+1)'(rtpls_pkg::JIT_ROUND);
        // truncate toward zero: arithmetic shift, bump negatives with a remainder
        q_shift = t_reg >>> rtpls_pkg::JIT_SHIFT;
        q_corr  = t_reg[rtpls_pkg::WORD_W] && (|t_reg[rtpls_pkg::JIT_SHIFT-1:0]);
        jitter_new = jitter_reg + q_shift[rtpls_pkg::WORD_W-1:0]
                   + {{(rtpls_pkg::WORD_W-1){1'b0}}, q_corr};

        q_data.recent_seq     = seq_reg;
        q_data.lost_total     = $signed(exp_tot_reg - rec_tot_reg);
        q_data.expected_total = exp_tot_reg;
        q_data.jitter_value   = $signed(jit_en_reg ? jitter_new : jitter_reg);
        q_data.received_count = rec_tot_reg;
        q_data.frac_en        = (exp_tot_reg > rec_tot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rtpls_pkg::F_IDLE;
            next_exp_reg <= '0;
            exp_tot_reg  <= '0;
            rec_tot_reg  <= '0;
            last_arr_reg <= '0;
            jitter_reg   <= '0;
            jit_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                next_exp_reg <= cfg_data;
            end
            else if (accept)
            begin
                next_exp_reg <= item.seq_number + rtpls_pkg::SEQ_W'(1);
            end
            if (accept)
            begin
                exp_tot_reg  <= exp_tot_reg + exp_add;
                rec_tot_reg  <= rec_tot_reg + rtpls_pkg::WORD_W'(1);
                last_arr_reg <= item.arrival_ms;
                jit_en_reg   <= (last_arr_reg != '0);
            end
            if (jit_upd && jit_en_reg)
            begin
                jitter_reg <= jitter_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg   <= item.seq_number;
            delta_reg <= item.arrival_ms - last_arr_reg;
        end
        if (state_reg == rtpls_pkg::F_DIFF)
        begin
            t_reg <= t_next;
        end
    end

endmodule

@@ rtl/rtpls_queue.sv @@
// ============================================================================
// rtpls_queue
// Short first-in first-out queue of requests between front and divider side.
// ============================================================================
module rtpls_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  rtpls_pkg::rtpls_job_t wr_data,
    output logic                  q_full,
    input  logic                  rd_en,
    output rtpls_pkg::rtpls_job_t rd_data,
    output logic                  q_empty
);

    rtpls_pkg::rtpls_job_t slot_reg [rtpls_pkg::QUEUE_DEPTH];

    logic [rtpls_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [rtpls_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [rtpls_pkg::QUEUE_AW:0]   count_reg;
    logic                           do_wr;
    logic                           do_rd;

    assign q_full  = (count_reg == (rtpls_pkg::QUEUE_AW+1)'(rtpls_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + rtpls_pkg::QUEUE_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + rtpls_pkg::QUEUE_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (rtpls_pkg::QUEUE_AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (rtpls_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/rtpls_back.sv @@
// ============================================================================
// rtpls_back
// Takes requests from the queue, works out the fraction lost with a bit-serial
// restoring divider and holds the result in the output register.
// ============================================================================
module rtpls_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  rtpls_pkg::rtpls_job_t   q_data,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output rtpls_pkg::rtpls_result_t result
);

    rtpls_pkg::rtpls_back_state_t state_reg, state_next;

    rtpls_pkg::rtpls_job_t        job_reg;
    rtpls_pkg::rtpls_result_t     out_reg;
    logic                         out_valid_reg;
    logic [rtpls_pkg::WORD_W-1:0] rem_reg;
    logic [rtpls_pkg::FRAC_W-1:0] quo_reg;
    logic [rtpls_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic                         take_job;
    logic                         div_step;
    logic                         load_out;
    logic [rtpls_pkg::WORD_W:0]   rem_shift;
    logic [rtpls_pkg::WORD_W:0]   rem_sub;
    logic                         q_bit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtpls_pkg::B_IDLE:
                if (!q_empty)
                    state_next = q_data.frac_en ? rtpls_pkg::B_DIV : rtpls_pkg::B_WAIT;
            rtpls_pkg::B_DIV:
                if (cnt_reg == rtpls_pkg::DIV_CNT_W'(1))
                    state_next = rtpls_pkg::B_WAIT;
            rtpls_pkg::B_WAIT:
                if (!out_valid_reg || pop)
                    state_next = rtpls_pkg::B_IDLE;
            default:
                state_next = rtpls_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        take_job = (state_reg == rtpls_pkg::B_IDLE) && !q_empty;
        div_step = (state_reg == rtpls_pkg::B_DIV);
        load_out = (state_reg == rtpls_pkg::B_WAIT) && (!out_valid_reg || pop);
        q_pop    = take_job;
    end

    // One quotient bit per cycle; the low bits of lost*256 are zero
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, job_reg.expected_total};
        q_bit     = (rem_shift >= {1'b0, job_reg.expected_total});
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtpls_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take_job)
            begin
                cnt_reg <= rtpls_pkg::DIV_CNT_W'(rtpls_pkg::FRAC_W);
            end
            else if (div_step)
            begin
                cnt_reg <= cnt_reg - rtpls_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            job_reg <= q_data;
            rem_reg <= q_data.lost_total;
            quo_reg <= '0;
        end
        else if (div_step)
        begin
            rem_reg <= q_bit ? rem_sub[rtpls_pkg::WORD_W-1:0]
                             : rem_shift[rtpls_pkg::WORD_W-1:0];
            quo_reg <= {quo_reg[rtpls_pkg::FRAC_W-2:0], q_bit};
        end
        if (load_out)
        begin
            out_reg.recent_seq     <= job_reg.recent_seq;
            out_reg.lost_total     <= job_reg.lost_total;
            out_reg.loss_fraction  <= quo_reg;
            out_reg.jitter_value   <= job_reg.jitter_value;
            out_reg.received_count <= job_reg.received_count;
        end
    end

endmodule

@@ rtl/rtp_receiver_loss_jitter_stats.sv @@
// ============================================================================
// rtp_receiver_loss_jitter_stats
// RTP receiver report-block statistics: loss, fraction lost, jitter.
// ============================================================================
// Path: an accepted packet request passes the front states F_DIFF and F_JIT,
// the request queue and the back side; when packets are lost, the 8-step
// bit-serial divider works out the fraction lost before the result is loaded.
// The input takes a new packet only after the front has queued the last one.
// Reset: rst_n clears all counters, jitter and queues at once; the expected
// sequence returns to zero until the configuration register is written or a packet is accepted.
module rtp_receiver_loss_jitter_stats (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtpls_pkg::SEQ_W-1:0]         cfg_data,
    input  logic                                push,
    output logic                                full,
    input  rtpls_pkg::rtpls_item_t              item,
    output logic                                empty,
    input  logic                                pop,
    output rtpls_pkg::rtpls_result_t            result
);

    // Requests between the front part and the divider side
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    rtpls_pkg::rtpls_job_t q_wr_data;
    rtpls_pkg::rtpls_job_t q_rd_data;

    // Front: accept a packet, advance sequence, totals and jitter state
    rtpls_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .item     (item),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_wr_data)
    );

    // Queue: hold finished front requests while the divider is busy
    rtpls_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Back: divide for the fraction lost and present the result
    rtpls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("request pushed into full queue");

    // A non-zero fraction lost implies some packets lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.loss_fraction != '0)) |-> (result.lost_total != '0))
        else $error("fraction lost without packets lost");

    // An accepted packet blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> full)
        else $error("input not blocked after accept");

    // A waiting result that is not taken stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

endmodule
